@@ rtl/core/triangle_face_normal_defines.svh @@
// Assertion helpers for the face normal block.
`ifndef TRIANGLE_FACE_NORMAL_DEFINES_SVH
`define TRIANGLE_FACE_NORMAL_DEFINES_SVH

// Checks a property on every clock edge outside reset.
`define TFN_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("face normal assertion failed");

// Checks that a condition implies a consequence on the same edge.
`define TFN_IMPLIES(lbl, cond, cons) \
    `TFN_ASSERT(lbl, (cond) |-> (cons))

`endif

@@ rtl/core/tfn_pkg.sv @@
// ----------------------------------------------------------------------------
// Face normal package
// Types, widths and constants shared by the face normal block and its cells.
// ----------------------------------------------------------------------------
`default_nettype none

package tfn_pkg;

    localparam int COORD_WIDTH      = 16;
    localparam int NORMAL_FRAC_BITS = 14;
    localparam int OUT_WIDTH        = 16;
    localparam int CFG_WIDTH        = 32;
    localparam logic [CFG_WIDTH-1:0] MIN_LENGTH_RESET = 32'd17;

    // Edge, cross product, square and root widths.
    localparam int EDGE_W = COORD_WIDTH + 1;
    localparam int PROD_W = 2 * EDGE_W;
    localparam int NRM_W  = PROD_W + 1;
    localparam int SQ_W   = 2 * NRM_W;
    localparam int LEN_W  = NRM_W + 1;
    localparam int SUM_W  = 2 * LEN_W;
    localparam int Q_W    = NORMAL_FRAC_BITS + 1;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] ax;
        logic signed [COORD_WIDTH-1:0] ay;
        logic signed [COORD_WIDTH-1:0] az;
        logic signed [COORD_WIDTH-1:0] bx;
        logic signed [COORD_WIDTH-1:0] by;
        logic signed [COORD_WIDTH-1:0] bz;
        logic signed [COORD_WIDTH-1:0] cx;
        logic signed [COORD_WIDTH-1:0] cy;
        logic signed [COORD_WIDTH-1:0] cz;
    } t_in;

    typedef struct packed {
        logic signed [OUT_WIDTH-1:0] norm_x;
        logic signed [OUT_WIDTH-1:0] norm_y;
        logic signed [OUT_WIDTH-1:0] norm_z;
        logic                        degenerate;
    } t_out;

endpackage

`default_nettype wire

@@ rtl/core/tfn_sqrt_cell.sv @@
// ----------------------------------------------------------------------------
// Square root cell
// One digit of a restoring integer square root, with side data riding along.
// ----------------------------------------------------------------------------
`default_nettype none

module tfn_sqrt_cell #(
    parameter int LW = tfn_pkg::LEN_W,
    parameter int DW = 8
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_en,
    input  wire logic            i_vld,
    input  wire logic [2*LW-1:0] i_rad,
    input  wire logic [LW+1:0]   i_rem,
    input  wire logic [LW-1:0]   i_root,
    input  wire logic [DW-1:0]   i_side,
    output logic                 o_vld,
    output logic [2*LW-1:0]      o_rad,
    output logic [LW+1:0]        o_rem,
    output logic [LW-1:0]        o_root,
    output logic [DW-1:0]        o_side
);

    logic [LW+3:0] rem_sh;
    logic [LW+3:0] trial;
    logic          ge;

    always_comb begin
        rem_sh = {i_rem, i_rad[2*LW-1 -: 2]};
        trial  = {2'b00, i_root, 2'b01};
        ge     = rem_sh >= trial;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_vld <= 1'b0;
        end else if (i_en) begin
            o_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_rad  <= {i_rad[2*LW-3:0], 2'b00};
            o_rem  <= ge ? (LW+2)'(rem_sh - trial) : rem_sh[LW+1:0];
            o_root <= {i_root[LW-2:0], ge};
            o_side <= i_side;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/tfn_div_cell.sv @@
// ----------------------------------------------------------------------------
// Divider cell
// One quotient bit, or with ROUND set the rounding step, for each of the three normal components.
// ----------------------------------------------------------------------------
`default_nettype none

module tfn_div_cell #(
    parameter int LW    = tfn_pkg::LEN_W,
    parameter int QW    = tfn_pkg::Q_W,
    parameter int DW    = 7,
    parameter bit ROUND = 1'b0
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_en,
    input  wire logic          i_vld,
    input  wire logic [LW-1:0] i_len,
    input  wire logic [LW-1:0] i_rem [3],
    input  wire logic [QW-1:0] i_q   [3],
    input  wire logic [DW-1:0] i_side,
    output logic               o_vld,
    output logic [LW-1:0]      o_len,
    output logic [LW-1:0]      o_rem [3],
    output logic [QW-1:0]      o_q   [3],
    output logic [DW-1:0]      o_side
);

    logic [LW:0]   dbl [3];
    logic          ge  [3];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            dbl[k] = {i_rem[k], 1'b0};
            ge[k]  = dbl[k] >= {1'b0, i_len};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_vld <= 1'b0;
        end else if (i_en) begin
            o_vld <= i_vld;
        end
    end

    // The last cell rounds to nearest instead of producing another bit.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_len  <= i_len;
            o_side <= i_side;
            for (int k = 0; k < 3; k++) begin
                o_rem[k] <= ge[k] ? LW'(dbl[k] - {1'b0, i_len}) : dbl[k][LW-1:0];
                if (ROUND) begin
                    o_q[k] <= i_q[k] + QW'(ge[k]);
                end else begin
                    o_q[k] <= {i_q[k][QW-2:0], ge[k]};
                end
            end
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/triangle_face_normal.sv @@
// Throughput: one triangle per cycle; every stage advances together whenever
// the output register is empty or its beat is taken.
// The pipeline runs through the front stages, the square root chain (one cell per
// root bit), the threshold stage, the divider chain and the output register.
// Reset (synchronous, active low) empties the pipeline and sets min_length to 17.
// ----------------------------------------------------------------------------
// Triangle face normal
// Cross product of two triangle edges normalized to a Q1.14 unit vector.
// ----------------------------------------------------------------------------
`default_nettype none

`include "triangle_face_normal_defines.svh"

module triangle_face_normal (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_valid,
    output logic                                   o_ready,
    input  wire tfn_pkg::t_in                      i_data,
    output logic                                   o_valid,
    input  wire logic                              i_ready,
    output tfn_pkg::t_out                          o_data,
    input  wire logic                              i_cfg_we,
    input  wire logic [tfn_pkg::CFG_WIDTH-1:0]     i_cfg_wdata
);

    localparam int EW = tfn_pkg::EDGE_W;
    localparam int PW = tfn_pkg::PROD_W;
    localparam int NW = tfn_pkg::NRM_W;
    localparam int QSW = tfn_pkg::SQ_W;
    localparam int LW = tfn_pkg::LEN_W;
    localparam int SW = tfn_pkg::SUM_W;
    localparam int NF = tfn_pkg::NORMAL_FRAC_BITS;
    localparam int QW = tfn_pkg::Q_W;
    localparam int OW = tfn_pkg::OUT_WIDTH;
    localparam int SDW = 3 * NW + 3;
    localparam int DDW = 7;

    logic en;
    logic [tfn_pkg::CFG_WIDTH-1:0] r_min_len;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_len <= tfn_pkg::MIN_LENGTH_RESET;
        end else if (i_cfg_we) begin
            r_min_len <= i_cfg_wdata;
        end
    end

    assign en      = !o_valid || i_ready;
    assign o_ready = en;

    // Front stages: edges, products, cross product, squares, sum.
    logic                 r_v1, r_v2, r_v3, r_v4, r_v5;
    logic signed [EW-1:0] r_e1 [3];
    logic signed [EW-1:0] r_e2 [3];
    logic signed [PW-1:0] r_p  [6];
    logic [NW-1:0]        r_mag3 [3];
    logic [2:0]           r_neg3;
    logic [NW-1:0]        r_mag4 [3];
    logic [2:0]           r_neg4;
    logic [QSW-1:0]       r_sq   [3];
    logic [NW-1:0]        r_mag5 [3];
    logic [2:0]           r_neg5;
    logic [SW-1:0]        r_sum;
    logic signed [NW-1:0] n_cross [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else if (en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
        end
    end

    always_comb begin
        n_cross[0] = NW'(r_p[0]) - NW'(r_p[1]);
        n_cross[1] = NW'(r_p[2]) - NW'(r_p[3]);
        n_cross[2] = NW'(r_p[4]) - NW'(r_p[5]);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_e1[0] <= EW'(i_data.bx) - EW'(i_data.ax);
            r_e1[1] <= EW'(i_data.by) - EW'(i_data.ay);
            r_e1[2] <= EW'(i_data.bz) - EW'(i_data.az);
            r_e2[0] <= EW'(i_data.cx) - EW'(i_data.ax);
            r_e2[1] <= EW'(i_data.cy) - EW'(i_data.ay);
            r_e2[2] <= EW'(i_data.cz) - EW'(i_data.az);
            r_p[0] <= r_e1[1] * r_e2[2];
            r_p[1] <= r_e1[2] * r_e2[1];
            r_p[2] <= r_e1[2] * r_e2[0];
            r_p[3] <= r_e1[0] * r_e2[2];
            r_p[4] <= r_e1[0] * r_e2[1];
            r_p[5] <= r_e1[1] * r_e2[0];
            for (int k = 0; k < 3; k++) begin
                r_neg3[k] <= n_cross[k][NW-1];
                r_mag3[k] <= n_cross[k][NW-1] ? NW'(-n_cross[k]) : NW'(n_cross[k]);
                r_sq[k]   <= r_mag3[k] * r_mag3[k];
                r_mag4[k] <= r_mag3[k];
                r_mag5[k] <= r_mag4[k];
            end
            r_neg4 <= r_neg3;
            r_neg5 <= r_neg4;
            r_sum  <= SW'(r_sq[0]) + SW'(r_sq[1]) + SW'(r_sq[2]);
        end
    end

    // Square root chain.
    logic            sq_vld  [LW+1];
    logic [SW-1:0]   sq_rad  [LW+1];
    logic [LW+1:0]   sq_rem  [LW+1];
    logic [LW-1:0]   sq_root [LW+1];
    logic [SDW-1:0]  sq_side [LW+1];

    assign sq_vld[0]  = r_v5;
    assign sq_rad[0]  = r_sum;
    assign sq_rem[0]  = '0;
    assign sq_root[0] = '0;
    assign sq_side[0] = {r_neg5, r_mag5[2], r_mag5[1], r_mag5[0]};

    for (genvar g = 0; g < LW; g++) begin : g_sqrt
        tfn_sqrt_cell #(.LW(LW), .DW(SDW)) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_en   (en),
            .i_vld  (sq_vld[g]),
            .i_rad  (sq_rad[g]),
            .i_rem  (sq_rem[g]),
            .i_root (sq_root[g]),
            .i_side (sq_side[g]),
            .o_vld  (sq_vld[g+1]),
            .o_rad  (sq_rad[g+1]),
            .o_rem  (sq_rem[g+1]),
            .o_root (sq_root[g+1]),
            .o_side (sq_side[g+1])
        );
    end

    // Threshold and saturation stage.
    logic            r_vt;
    logic [LW-1:0]   r_len_t;
    logic [LW-1:0]   r_rem_t [3];
    logic [2:0]      r_sat_t;
    logic [2:0]      r_neg_t;
    logic            r_deg_t;
    logic [NW-1:0]   sq_mag [3];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            sq_mag[k] = sq_side[LW][k*NW +: NW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vt <= 1'b0;
        end else if (en) begin
            r_vt <= sq_vld[LW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_len_t <= sq_root[LW];
            r_neg_t <= sq_side[LW][3*NW +: 3];
            r_deg_t <= sq_root[LW] <= LW'(r_min_len);
            for (int k = 0; k < 3; k++) begin
                r_sat_t[k] <= LW'(sq_mag[k]) >= sq_root[LW];
                r_rem_t[k] <= (LW'(sq_mag[k]) >= sq_root[LW]) ? '0 : LW'(sq_mag[k]);
            end
        end
    end

    // Divider chain: NF quotient bits, then one rounding cell.
    logic            dv_vld  [NF+2];
    logic [LW-1:0]   dv_len  [NF+2];
    logic [LW-1:0]   dv_rem  [NF+2][3];
    logic [QW-1:0]   dv_q    [NF+2][3];
    logic [DDW-1:0]  dv_side [NF+2];

    assign dv_vld[0]  = r_vt;
    assign dv_len[0]  = r_len_t;
    assign dv_side[0] = {r_deg_t, r_sat_t, r_neg_t};
    for (genvar k = 0; k < 3; k++) begin : g_dv_init
        assign dv_rem[0][k] = r_rem_t[k];
        assign dv_q[0][k]   = '0;
    end

    for (genvar g = 0; g <= NF; g++) begin : g_div
        tfn_div_cell #(.LW(LW), .QW(QW), .DW(DDW), .ROUND(g == NF)) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_en   (en),
            .i_vld  (dv_vld[g]),
            .i_len  (dv_len[g]),
            .i_rem  (dv_rem[g]),
            .i_q    (dv_q[g]),
            .i_side (dv_side[g]),
            .o_vld  (dv_vld[g+1]),
            .o_len  (dv_len[g+1]),
            .o_rem  (dv_rem[g+1]),
            .o_q    (dv_q[g+1]),
            .o_side (dv_side[g+1])
        );
    end

    // Output register.
    logic [OW-1:0]   n_comp [3];
    logic            dv_deg;
    logic [2:0]      dv_sat;
    logic [2:0]      dv_neg;

    always_comb begin
        dv_deg = dv_side[NF+1][6];
        dv_sat = dv_side[NF+1][5:3];
        dv_neg = dv_side[NF+1][2:0];
        for (int k = 0; k < 3; k++) begin
            n_comp[k] = dv_sat[k] ? (OW'(1) << NF) : OW'(dv_q[NF+1][k]);
            if (dv_neg[k]) begin
                n_comp[k] = OW'(-n_comp[k]);
            end
            if (dv_deg) begin
                n_comp[k] = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (en) begin
            o_valid <= dv_vld[NF+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            o_data.norm_x     <= n_comp[0];
            o_data.norm_y     <= n_comp[1];
            o_data.norm_z     <= n_comp[2];
            o_data.degenerate <= dv_deg;
        end
    end

    `TFN_IMPLIES(a_deg_zero, o_valid && o_data.degenerate,
        o_data.norm_x == 0 && o_data.norm_y == 0 && o_data.norm_z == 0)
    `TFN_IMPLIES(a_unit_range, o_valid,
        o_data.norm_x <= 16384 && o_data.norm_x >= -16384 &&
        o_data.norm_y <= 16384 && o_data.norm_y >= -16384)
    `TFN_IMPLIES(a_stall_hold, o_valid && !i_ready, ##1 o_valid && $stable(o_data))

endmodule

`default_nettype wire
